>>> rtl/ftm_pkg.sv
// Shared types and curve constants for the filmic tone map pipeline.
`timescale 1ns / 1ps
`default_nettype none

package ftm_pkg;

    // Output precision is fixed by the 17-bit result fields.
    localparam int OUT_FRAC_BITS = 16;
    localparam int OUT_W         = OUT_FRAC_BITS + 1;
    localparam int NUM_LANES     = 3;
    localparam int POLY_STAGES   = 4;

    // Internal widths: positive magnitude, first products, linear sums,
    // low partial products and full numerator/denominator.
    localparam int MAG_W  = 31;
    localparam int MUL_W  = 49;
    localparam int SUM_W  = 50;
    localparam int PLO_W  = 63;
    localparam int PROD_W = 82;
    localparam int REM_W  = 83;

    typedef logic [MAG_W-1:0]  t_mag;
    typedef logic [MUL_W-1:0]  t_mul;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [PLO_W-1:0]  t_plo;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [REM_W-1:0]  t_rem;
    typedef logic [OUT_W-1:0]  t_out;

    // Curve constants with 16 fraction bits, rounded to nearest.
    localparam logic [17:0] K_NUM_SQ    = 18'd164495;
    localparam logic [10:0] K_NUM_LIN   = 11'd1966;
    localparam logic [17:0] K_DEN_SQ    = 18'd159252;
    localparam logic [15:0] K_DEN_LIN   = 16'd38666;
    localparam logic [13:0] K_DEN_CONST = 14'd9175;

    localparam t_out OUT_ONE = t_out'(1) << OUT_FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] red_in;
        logic signed [31:0] green_in;
        logic signed [31:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
    } t_pix_out;

endpackage

`default_nettype wire

>>> rtl/ftm_poly.sv
// One lane's numerator and denominator polynomials, four pipeline stages.
`timescale 1ns / 1ps
`default_nettype none

module ftm_poly #(
    parameter int IN_FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic [3:0]                i_en,
    input  wire logic signed [31:0]        i_x,
    output logic      [ftm_pkg::PROD_W-1:0] o_p,
    output logic      [ftm_pkg::PROD_W-1:0] o_q,
    output logic                           o_zero
);

    localparam ftm_pkg::t_sum  C_NUM_LIN =
        ftm_pkg::t_sum'(ftm_pkg::K_NUM_LIN) << IN_FRAC_BITS;
    localparam ftm_pkg::t_sum  C_DEN_LIN =
        ftm_pkg::t_sum'(ftm_pkg::K_DEN_LIN) << IN_FRAC_BITS;
    localparam ftm_pkg::t_prod C_DEN_CONST =
        ftm_pkg::t_prod'(ftm_pkg::K_DEN_CONST) << (2 * IN_FRAC_BITS);

    ftm_pkg::t_mag  r_x0, r_x1;
    logic           r_z0, r_z1, r_z2, r_z3;
    ftm_pkg::t_mul  r_an, r_ad;
    ftm_pkg::t_sum  r_sn, r_sd;
    ftm_pkg::t_plo  r_pn_lo, r_pd_lo;
    ftm_pkg::t_mul  r_pn_hi, r_pd_hi;
    ftm_pkg::t_prod r_p, r_q;

    // Stage 0: square-term coefficients times x.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x0 <= i_x[30:0];
            r_z0 <= i_x[31] || (i_x == 32'sd0);
            r_an <= ftm_pkg::t_mul'(ftm_pkg::K_NUM_SQ) * ftm_pkg::t_mul'(i_x[30:0]);
            r_ad <= ftm_pkg::t_mul'(ftm_pkg::K_DEN_SQ) * ftm_pkg::t_mul'(i_x[30:0]);
        end
    end

    // Stage 1: add the linear coefficients.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_x1 <= r_x0;
            r_z1 <= r_z0;
            r_sn <= ftm_pkg::t_sum'(r_an) + C_NUM_LIN;
            r_sd <= ftm_pkg::t_sum'(r_ad) + C_DEN_LIN;
        end
    end

    // Stage 2: x times the sums, split into low and high partial products.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_z2    <= r_z1;
            r_pn_lo <= ftm_pkg::t_plo'(r_x1) * ftm_pkg::t_plo'(r_sn[31:0]);
            r_pd_lo <= ftm_pkg::t_plo'(r_x1) * ftm_pkg::t_plo'(r_sd[31:0]);
            r_pn_hi <= ftm_pkg::t_mul'(r_x1) *
                       ftm_pkg::t_mul'(r_sn[ftm_pkg::SUM_W-1:32]);
            r_pd_hi <= ftm_pkg::t_mul'(r_x1) *
                       ftm_pkg::t_mul'(r_sd[ftm_pkg::SUM_W-1:32]);
        end
    end

    // Stage 3: recombine partial products; the denominator gets its constant.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_z3 <= r_z2;
            r_p  <= ftm_pkg::t_prod'(r_pn_lo) + (ftm_pkg::t_prod'(r_pn_hi) << 32);
            r_q  <= ftm_pkg::t_prod'(r_pd_lo) + (ftm_pkg::t_prod'(r_pd_hi) << 32)
                    + C_DEN_CONST;
        end
    end

    assign o_p    = r_p;
    assign o_q    = r_q;
    assign o_zero = r_z3;

endmodule

`default_nettype wire

>>> rtl/ftm_div.sv
// One lane's saturation check and pipelined restoring divider.
`timescale 1ns / 1ps
`default_nettype none

module ftm_div (
    input  wire logic                          i_clk,
    input  wire logic [ftm_pkg::OUT_FRAC_BITS:0] i_en,
    input  wire logic [ftm_pkg::PROD_W-1:0]    i_p,
    input  wire logic [ftm_pkg::PROD_W-1:0]    i_q,
    input  wire logic                          i_zero,
    output logic [ftm_pkg::OUT_FRAC_BITS-1:0]  o_quo,
    output logic                               o_sat,
    output logic                               o_zero
);

    localparam int O = ftm_pkg::OUT_FRAC_BITS;

    ftm_pkg::t_prod         r_rem [O];
    ftm_pkg::t_prod         r_den [O];
    logic                   r_sat [O+1];
    logic                   r_z   [O+1];
    logic [O-1:0]           r_quo [1:O];

    // Stage 0: a curve value at or above one saturates.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= i_p;
            r_den[0] <= i_q;
            r_sat[0] <= (i_p >= i_q);
            r_z[0]   <= i_zero;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 1; j <= O; j++) begin : g_step
        ftm_pkg::t_rem w_rem2;
        logic          w_ge;

        assign w_rem2 = ftm_pkg::t_rem'(r_rem[j-1]) << 1;
        assign w_ge   = (w_rem2 >= ftm_pkg::t_rem'(r_den[j-1]));

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_sat[j] <= r_sat[j-1];
                r_z[j]   <= r_z[j-1];
            end
        end

        if (j == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_quo[j] <= O'(w_ge);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_quo[j] <= {r_quo[j-1][O-2:0], w_ge};
                end
            end
        end

        if (j < O) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= w_ge ? ftm_pkg::t_prod'(w_rem2 - ftm_pkg::t_rem'(r_den[j-1]))
                                     : ftm_pkg::t_prod'(w_rem2);
                    r_den[j] <= r_den[j-1];
                end
            end
        end
    end

    assign o_quo  = r_quo[O];
    assign o_sat  = r_sat[O];
    assign o_zero = r_z[O];

endmodule

`default_nettype wire

>>> rtl/filmic_tone_map_rgb.sv
// Pipeline: 4 polynomial stages, one saturation check, 16 divider stages and one output
// register. Throughput: one item per cycle unless the output stalls; each stage of the
// three lanes holds one item, and bubbles close up, so input is taken while a finished
// result waits downstream, as long as any stage is empty.
// Reset (synchronous, active low) clears every stage's valid flag; data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module filmic_tone_map_rgb #(
    parameter int IN_FRAC_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire ftm_pkg::t_pix_in i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output ftm_pkg::t_pix_out     o_out_data
);

    localparam int O     = ftm_pkg::OUT_FRAC_BITS;
    localparam int PS    = ftm_pkg::POLY_STAGES;
    localparam int N_OUT = PS + 1 + O;
    localparam int L     = ftm_pkg::NUM_LANES;

    logic [N_OUT:0] r_vld;
    logic [N_OUT:0] w_en;

    // A stage loads when it is empty or its contents move on.
    assign w_en[N_OUT] = !r_vld[N_OUT] || i_out_ready;
    for (genvar k = 0; k < N_OUT; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k <= N_OUT; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    logic signed [31:0]        w_x    [L];
    ftm_pkg::t_prod            w_p    [L];
    ftm_pkg::t_prod            w_q    [L];
    logic                      w_pz   [L];
    logic [O-1:0]              w_quo  [L];
    logic                      w_sat  [L];
    logic                      w_zero [L];
    ftm_pkg::t_out             w_res  [L];

    assign w_x[0] = i_in_data.red_in;
    assign w_x[1] = i_in_data.green_in;
    assign w_x[2] = i_in_data.blue_in;

    for (genvar c = 0; c < L; c++) begin : g_lane
        ftm_poly #(
            .IN_FRAC_BITS (IN_FRAC_BITS)
        ) u_poly (
            .i_clk  (i_clk),
            .i_en   (w_en[PS-1:0]),
            .i_x    (w_x[c]),
            .o_p    (w_p[c]),
            .o_q    (w_q[c]),
            .o_zero (w_pz[c])
        );

        ftm_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en[PS+O:PS]),
            .i_p    (w_p[c]),
            .i_q    (w_q[c]),
            .i_zero (w_pz[c]),
            .o_quo  (w_quo[c]),
            .o_sat  (w_sat[c]),
            .o_zero (w_zero[c])
        );

        // Non-positive input gives zero; a curve at or above one clamps.
        assign w_res[c] = w_zero[c] ? '0 :
                          w_sat[c]  ? ftm_pkg::OUT_ONE :
                                      ftm_pkg::t_out'(w_quo[c]);
    end

    ftm_pkg::t_pix_out r_out;

    always_ff @(posedge i_clk) begin
        if (w_en[N_OUT]) begin
            r_out.red_out   <= w_res[0];
            r_out.green_out <= w_res[1];
            r_out.blue_out  <= w_res[2];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[N_OUT];
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the filmic_tone_map_rgb pixel pipeline.
`timescale 1ns / 1ps

module tb_top;

    localparam int IN_FRAC      = 16;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;

    // Curve coefficients with 16 fraction bits, kept apart from the RTL copies.
    localparam logic [127:0] C_NUM_SQ    = 128'd164495;
    localparam logic [127:0] C_NUM_LIN   = 128'd1966;
    localparam logic [127:0] C_DEN_SQ    = 128'd159252;
    localparam logic [127:0] C_DEN_LIN   = 128'd38666;
    localparam logic [127:0] C_DEN_CONST = 128'd9175;

    typedef struct {
        ftm_pkg::t_pix_in  px;
        ftm_pkg::t_pix_out tone;
    } t_tone_entry;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    ftm_pkg::t_pix_in  in_data   = '0;
    logic              out_ready = 1'b0;
    logic              in_ready;
    logic              out_valid;
    ftm_pkg::t_pix_out out_data;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;
    bit  hold_taken     = 1'b0;
    int  hold_left      = 0;
    int  error_count    = 0;

    t_tone_entry expected_tones[$];

    filmic_tone_map_rgb #(
        .IN_FRAC_BITS(IN_FRAC)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Exact rational curve on wide integers; the quotient is truncated.
    function automatic ftm_pkg::t_out curve_value(input logic signed [31:0] x);
        logic [127:0] xv;
        logic [127:0] numer;
        logic [127:0] denom;
        logic [127:0] quo;
        if (x <= 0)
            return '0;
        xv    = 128'(unsigned'(x));
        numer = xv * (xv * C_NUM_SQ + (C_NUM_LIN << IN_FRAC));
        denom = xv * (xv * C_DEN_SQ + (C_DEN_LIN << IN_FRAC)) + (C_DEN_CONST << (2 * IN_FRAC));
        if (numer >= denom)
            return ftm_pkg::t_out'(1) << ftm_pkg::OUT_FRAC_BITS;
        quo = (numer << ftm_pkg::OUT_FRAC_BITS) / denom;
        return ftm_pkg::t_out'(quo);
    endfunction

    function automatic ftm_pkg::t_pix_out tone_map_pixel(input ftm_pkg::t_pix_in px);
        ftm_pkg::t_pix_out res;
        res.red_out   = curve_value(px.red_in);
        res.green_out = curve_value(px.green_in);
        res.blue_out  = curve_value(px.blue_in);
        return res;
    endfunction

    function automatic ftm_pkg::t_pix_in make_pixel(input logic [31:0] r,
                                                    input logic [31:0] g,
                                                    input logic [31:0] b);
        ftm_pkg::t_pix_in px;
        px.red_in   = r;
        px.green_in = g;
        px.blue_in  = b;
        return px;
    endfunction

    // Weighted toward the part of the curve that bends, including the knee near 7.24.
    function automatic logic [31:0] random_channel();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(9))
            0: return raw;
            1: return {1'b1, raw[30:0]};
            2: return 32'd0;
            3, 4: return $urandom_range(0, 16 << IN_FRAC);
            5: return $urandom_range(0, 2 << IN_FRAC);
            6: return $urandom_range(458752, 491520);
            7: return $urandom_range(0, 1023);
            default: return {1'b0, raw[30:0]};
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_pixel(input ftm_pkg::t_pix_in px);
        t_tone_entry entry;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge clk); while (!in_ready);
        entry.px   = px;
        entry.tone = tone_map_pixel(px);
        expected_tones.push_back(entry);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_tones.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, or one long hold-off when asked for.
    always @(posedge clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            if (!hold_req)
                hold_taken <= 1'b0;
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: every accepted item is compared with the oldest prediction.
    always @(posedge clk) begin
        t_tone_entry want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_tones.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", out_data));
            end else begin
                want = expected_tones.pop_front();
                if (out_data.red_out !== want.tone.red_out)
                    report_mismatch($sformatf("red in=%h got %h want %h", want.px.red_in,
                                              out_data.red_out, want.tone.red_out));
                if (out_data.green_out !== want.tone.green_out)
                    report_mismatch($sformatf("green in=%h got %h want %h", want.px.green_in,
                                              out_data.green_out, want.tone.green_out));
                if (out_data.blue_out !== want.tone.blue_out)
                    report_mismatch($sformatf("blue in=%h got %h want %h", want.px.blue_in,
                                              out_data.blue_out, want.tone.blue_out));
            end
        end
    end

    task automatic test_directed_corners();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pixel(make_pixel(32'd0, 32'd0, 32'd0));
        send_pixel(make_pixel(32'd1, 32'd2, 32'd3));
        send_pixel(make_pixel(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send_pixel(make_pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        send_pixel(make_pixel(32'd65536, 32'd11796, 32'd131072));
        send_pixel(make_pixel(32'hFFFF_0000, 32'd65536, 32'hFFFF_FFFE));
        // Around the point where the curve reaches one.
        send_pixel(make_pixel(32'd474000, 32'd474500, 32'd474700));
        send_pixel(make_pixel(32'd474800, 32'd475000, 32'd480000));
        send_pixel(make_pixel(32'd474600, 32'd474650, 32'd474550));
        send_pixel(make_pixel(32'd458752, 32'd491520, 32'd655360));
        send_pixel(make_pixel(32'h4000_0000, 32'h0000_FFFF, 32'h0001_0001));
        send_pixel(make_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h2AAA_AAAA));
        send_pixel(make_pixel(32'd16, 32'd256, 32'd4096));
        send_pixel(make_pixel(32'd32768, 32'd6554, 32'd327680));
        send_pixel(make_pixel(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1));
    endtask

    task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_pixel(make_pixel(random_channel(), random_channel(), random_channel()));
    endtask

    // The receiver stops for a long stretch while items keep coming, filling the pipe.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 10;
        hold_req <= 1'b1;
        repeat (60)
            send_pixel(make_pixel(random_channel(), random_channel(), random_channel()));
        while (hold_left != 0)
            @(posedge clk);
        hold_req <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_random_mix(220, 0, 0);
        test_random_mix(210, 76, 0);
        test_random_mix(210, 0, 76);
        test_random_mix(210, 23, 23);
        test_output_backpressure();
        test_random_mix(40, 0, 0);
        wait_drained();
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
